/* hdl/keypad_square_display_unit_macros.svh */
// Assertion macros for the keypad square display unit.
// Used by the top level; needs a clk and rst in scope.
`ifndef KEYPAD_SQUARE_DISPLAY_UNIT_MACROS_SVH
`define KEYPAD_SQUARE_DISPLAY_UNIT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define KPSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define KPSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/kpsd_pkg.sv */
// Shared types, constants and lookup functions for the keypad square display unit.
// No dependencies.
`timescale 1ns / 1ps

package kpsd_pkg;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd5;
  localparam logic [7:0] DIGIT_RESET    = 8'd1;

  // Register index decoded from paddr[2].
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_DIGIT    = 1'b1;

  localparam logic [7:0] SEL_HUNDREDS = 8'hfe;
  localparam logic [7:0] SEL_TENS     = 8'hfb;
  localparam logic [7:0] SEL_ONES     = 8'hef;

  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  // Scanner view of one transfer: row driven and key/digits after the update.
  typedef struct packed {
    logic [3:0] row_drive;
    logic [4:0] key_code;
    digits_t    digits;
  } scan_view_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic [7:0] segments;
    logic [7:0] digit_select;
    logic [4:0] key_code;
    logic [8:0] square_value;
  } result_t;

  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'h0: s = 8'h3f;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5b;
      4'h3: s = 8'h4f;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6d;
      4'h6: s = 8'h7d;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7f;
      4'h9: s = 8'h6f;
      4'ha: s = 8'h77;
      4'hb: s = 8'h7c;
      4'hc: s = 8'h39;
      4'hd: s = 8'h5e;
      4'he: s = 8'h79;
      default: s = 8'h71;
    endcase
    return s;
  endfunction

  // Decimal digits of key squared.
  function automatic digits_t square_digits(input logic [4:0] key);
    digits_t r;
    case (key)
      5'd1:  r = '{4'd0, 4'd0, 4'd1};
      5'd2:  r = '{4'd0, 4'd0, 4'd4};
      5'd3:  r = '{4'd0, 4'd0, 4'd9};
      5'd4:  r = '{4'd0, 4'd1, 4'd6};
      5'd5:  r = '{4'd0, 4'd2, 4'd5};
      5'd6:  r = '{4'd0, 4'd3, 4'd6};
      5'd7:  r = '{4'd0, 4'd4, 4'd9};
      5'd8:  r = '{4'd0, 4'd6, 4'd4};
      5'd9:  r = '{4'd0, 4'd8, 4'd1};
      5'd10: r = '{4'd1, 4'd0, 4'd0};
      5'd11: r = '{4'd1, 4'd2, 4'd1};
      5'd12: r = '{4'd1, 4'd4, 4'd4};
      5'd13: r = '{4'd1, 4'd6, 4'd9};
      5'd14: r = '{4'd1, 4'd9, 4'd6};
      5'd15: r = '{4'd2, 4'd2, 4'd5};
      5'd16: r = '{4'd2, 4'd5, 4'd6};
      default: r = '{4'd0, 4'd0, 4'd0};
    endcase
    return r;
  endfunction

endpackage

/* hdl/kpsd_scan.sv */
// Row scanner, debounce and key capture; splits key squared at each scan wrap.
// Depends on kpsd_pkg.
`timescale 1ns / 1ps

module kpsd_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [3:0]             col_sense,
  input  logic [7:0]             debounce_ticks,
  output kpsd_pkg::scan_view_t   view
);
  import kpsd_pkg::*;

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_RELEASE  = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [1:0] scan_row, scan_row_next;
  logic [7:0] debounce_count, debounce_count_next;
  logic [4:0] held_key, held_key_next;
  digits_t    digits, digits_next;

  logic [7:0] count_dec;
  logic [1:0] col;
  logic       col_ok;
  logic       advance;

  always_comb begin
    col    = 2'd0;
    col_ok = 1'b1;
    unique case (col_sense)
      4'he:    col = 2'd0;
      4'hd:    col = 2'd1;
      4'hb:    col = 2'd2;
      4'h7:    col = 2'd3;
      default: col_ok = 1'b0;
    endcase
  end

  assign count_dec = (debounce_count != 8'd0) ? debounce_count - 8'd1 : 8'd0;

  always_comb begin
    phase_next          = phase;
    debounce_count_next = debounce_count;
    held_key_next       = held_key;
    advance             = 1'b0;
    unique case (phase)
      PH_DEBOUNCE: begin
        debounce_count_next = count_dec;
        if (count_dec == 8'd0) begin
          if (col_sense == 4'hf) begin
            phase_next = PH_SCAN;
            advance    = 1'b1;
          end else begin
            if (col_ok) held_key_next = {1'b0, scan_row, col} + 5'd1;
            phase_next = PH_RELEASE;
          end
        end
      end
      PH_RELEASE: begin
        if (col_sense == 4'hf) begin
          phase_next = PH_SCAN;
          advance    = 1'b1;
        end
      end
      default: begin
        phase_next = PH_SCAN;
        if (col_sense != 4'hf) begin
          phase_next          = PH_DEBOUNCE;
          debounce_count_next = (debounce_ticks != 8'd0) ? debounce_ticks : 8'd1;
        end else begin
          advance = 1'b1;
        end
      end
    endcase

    scan_row_next = scan_row;
    digits_next   = digits;
    if (advance) begin
      scan_row_next = scan_row + 2'd1;
      if (scan_row == 2'd3) digits_next = square_digits(held_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      scan_row       <= 2'd0;
      debounce_count <= 8'd0;
      held_key       <= 5'd0;
      digits         <= '0;
    end else if (step) begin
      phase          <= phase_next;
      scan_row       <= scan_row_next;
      debounce_count <= debounce_count_next;
      held_key       <= held_key_next;
      digits         <= digits_next;
    end
  end

  assign view.row_drive = ~(4'b0001 << scan_row);
  assign view.key_code  = held_key_next;
  assign view.digits    = digits_next;

endmodule

/* hdl/kpsd_disp.sv */
// Three-digit seven-segment multiplex with programmable dwell per digit.
// Depends on kpsd_pkg.
`timescale 1ns / 1ps

module kpsd_disp (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        digit_ticks,
  input  kpsd_pkg::digits_t digits,
  output logic [7:0]        segments,
  output logic [7:0]        digit_select
);
  import kpsd_pkg::*;

  logic [1:0] shown_digit, shown_digit_next;
  logic [7:0] digit_count, digit_count_next;
  logic [7:0] limit;
  logic [7:0] count_inc;
  logic [3:0] d;

  always_comb begin
    unique case (shown_digit)
      2'd1: begin
        d            = digits.tens;
        digit_select = SEL_TENS;
      end
      2'd2: begin
        d            = digits.hundreds;
        digit_select = SEL_HUNDREDS;
      end
      default: begin
        d            = digits.ones;
        digit_select = SEL_ONES;
      end
    endcase
  end

  assign segments  = seg_font(d);
  assign limit     = (digit_ticks != 8'd0) ? digit_ticks : 8'd1;
  assign count_inc = digit_count + 8'd1;

  always_comb begin
    digit_count_next = count_inc;
    shown_digit_next = shown_digit;
    if (count_inc >= limit) begin
      digit_count_next = 8'd0;
      shown_digit_next = (shown_digit >= 2'd2) ? 2'd0 : shown_digit + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_digit <= 2'd0;
      digit_count <= 8'd0;
    end else if (step) begin
      shown_digit <= shown_digit_next;
      digit_count <= digit_count_next;
    end
  end

endmodule

/* hdl/keypad_square_display_unit.sv */
// An accepted transfer's result is registered into the output register, or into the skid
// register if the output is stalled. Throughput: one transfer per clock; the skid register
// takes one more transfer while a result is stalled, then in_stall rises until the output is popped.
// Reset (rst, synchronous): scan at row 0, key and digits 0, debounce_ticks 5,
// digit_ticks 1, output and skid registers empty.
`timescale 1ns / 1ps
`include "keypad_square_display_unit_macros.svh"

module keypad_square_display_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  col_sense,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  row_drive,
  output logic [7:0]  segments,
  output logic [7:0]  digit_select,
  output logic [4:0]  key_code,
  output logic [8:0]  square_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kpsd_pkg::*;

  logic [7:0] debounce_ticks;
  logic [7:0] digit_ticks;
  logic       cfg_write;

  logic       step;
  logic       pop;
  scan_view_t view;
  logic [7:0] seg_new;
  logic [7:0] sel_new;
  result_t    result_new;
  result_t    out_reg;
  result_t    skid_reg;
  logic       skid_valid;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      digit_ticks    <= DIGIT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_DEBOUNCE: debounce_ticks <= pwdata[7:0];
        REG_DIGIT:    digit_ticks    <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE: prdata = {24'd0, debounce_ticks};
      REG_DIGIT:    prdata = {24'd0, digit_ticks};
      default:      prdata = 32'd0;
    endcase
  end

  assign in_stall = skid_valid;
  assign step     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  kpsd_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .col_sense      (col_sense),
    .debounce_ticks (debounce_ticks),
    .view           (view)
  );

  kpsd_disp u_disp (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .digit_ticks  (digit_ticks),
    .digits       (view.digits),
    .segments     (seg_new),
    .digit_select (sel_new)
  );

  always_comb begin
    result_new.row_drive    = view.row_drive;
    result_new.segments     = seg_new;
    result_new.digit_select = sel_new;
    result_new.key_code     = view.key_code;
    result_new.square_value = 9'(view.digits.hundreds) * 9'd100
                            + 9'(view.digits.tens) * 9'd10
                            + 9'(view.digits.ones);
  end

  // Output register plus one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (step) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (!out_valid || pop) out_reg <= result_new;
      else skid_reg <= result_new;
    end else if (pop && skid_valid) begin
      out_reg <= skid_reg;
    end
  end

  assign row_drive    = out_reg.row_drive;
  assign segments     = out_reg.segments;
  assign digit_select = out_reg.digit_select;
  assign key_code     = out_reg.key_code;
  assign square_value = out_reg.square_value;

  `KPSD_ASSERT(a_skid_behind_out, !skid_valid || out_valid, "skid full with empty output")
  `KPSD_ASSERT_NEXT(a_transfer_lands, step, out_valid, "accepted transfer produced no result")
  `KPSD_ASSERT(a_row_one_cold, !out_valid || $countones(row_drive) == 3, "row drive not one-cold")
  `KPSD_ASSERT(a_select_code, !out_valid || digit_select == SEL_ONES || digit_select == SEL_TENS || digit_select == SEL_HUNDREDS, "bad digit select")
  `KPSD_ASSERT(a_key_range, !out_valid || key_code <= 5'd16, "key code out of range")

endmodule
